// ===== sv/depth_pixel_backprojection_macros.svh =====
// assertion macros shared by the depth back-projection block
`ifndef DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH
`define DEPTH_PIXEL_BACKPROJECTION_MACROS_SVH

// checked outside reset
`define DPB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define DPB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dpb_pkg.sv =====
// types and constants shared by the depth back-projection block
`default_nettype none

package dpb_pkg;

  // datapath operation codes
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE = 4'd0;
  localparam op_t OP_MX   = 4'd1;
  localparam op_t OP_MY   = 4'd2;
  localparam op_t OP_Z    = 4'd3;
  localparam op_t OP_XL   = 4'd4;
  localparam op_t OP_XH   = 4'd5;
  localparam op_t OP_XS   = 4'd6;
  localparam op_t OP_YL   = 4'd7;
  localparam op_t OP_YH   = 4'd8;
  localparam op_t OP_YS   = 4'd9;

  // register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PRINCIPAL_X  = 3'd0;
  localparam cfg_idx_t CFG_PRINCIPAL_Y  = 3'd1;
  localparam cfg_idx_t CFG_SCALE_X      = 3'd2;
  localparam cfg_idx_t CFG_SCALE_Y      = 3'd3;
  localparam cfg_idx_t CFG_DEPTH_SCALE  = 3'd4;
  localparam cfg_idx_t CFG_FRAME_WIDTH  = 3'd5;
  localparam cfg_idx_t CFG_FRAME_HEIGHT = 3'd6;
  localparam cfg_idx_t CFG_COLOR_ORDER  = 3'd7;

  // colour order codes
  localparam logic [1:0] ORDER_RGB  = 2'd0;
  localparam logic [1:0] ORDER_BGR  = 2'd1;
  localparam logic [1:0] ORDER_MONO = 2'd2;

  localparam logic [31:0] DEPTH_SCALE_RESET = 32'd4294967;
  localparam logic [12:0] WIDTH_RESET       = 13'd640;
  localparam logic [12:0] HEIGHT_RESET      = 13'd480;
  localparam logic [7:0]  ALPHA_VALUE       = 8'd255;
  localparam logic [31:0] Q1616_POS_MAX     = 32'h7fff_ffff;
  localparam logic [32:0] Q1616_NEG_MAG     = 33'h0_8000_0000;

  typedef struct packed {
    logic load;
    op_t  op;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/dpb_ctrl.sv =====
// sequencer for the depth back-projection datapath
`default_nettype none

module dpb_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dpb_pkg::dp_status_t status,
  output dpb_pkg::dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_Z    = 4'd3;
  localparam logic [3:0] S_XL   = 4'd4;
  localparam logic [3:0] S_XH   = 4'd5;
  localparam logic [3:0] S_XS   = 4'd6;
  localparam logic [3:0] S_YL   = 4'd7;
  localparam logic [3:0] S_YH   = 4'd8;
  localparam logic [3:0] S_YS   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.op      = dpb_pkg::OP_NONE;
    cmd.publish = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MX;
        end
      end
      S_MX: begin
        cmd.op     = dpb_pkg::OP_MX;
        state_next = S_MY;
      end
      S_MY: begin
        cmd.op     = dpb_pkg::OP_MY;
        state_next = S_Z;
      end
      S_Z: begin
        cmd.op     = dpb_pkg::OP_Z;
        state_next = S_XL;
      end
      S_XL: begin
        cmd.op     = dpb_pkg::OP_XL;
        state_next = S_XH;
      end
      S_XH: begin
        cmd.op     = dpb_pkg::OP_XH;
        state_next = S_XS;
      end
      S_XS: begin
        cmd.op     = dpb_pkg::OP_XS;
        state_next = S_YL;
      end
      S_YL: begin
        cmd.op     = dpb_pkg::OP_YL;
        state_next = S_YH;
      end
      S_YH: begin
        cmd.op     = dpb_pkg::OP_YH;
        state_next = S_YS;
      end
      S_YS: begin
        cmd.op     = dpb_pkg::OP_YS;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dpb_datapath.sv =====
// registers, counters, shared multiplier and output stage of the back-projection
`default_nettype none

module dpb_datapath #(
  parameter int COORD_BITS = 12
) (
  input  wire                      clk,
  input  wire                      rst,
  input  dpb_pkg::dp_cmd_t         cmd,
  output dpb_pkg::dp_status_t      status,
  input  wire                      cfg_valid,
  input  wire [2:0]                cfg_index,
  input  wire [31:0]               cfg_data,
  input  wire [15:0]               depth_raw,
  input  wire [7:0]                color_byte0,
  input  wire [7:0]                color_byte1,
  input  wire [7:0]                color_byte2,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [31:0]       point_x,
  output logic signed [31:0]       point_y,
  output logic [30:0]              point_z,
  output logic                     point_valid,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue,
  output logic [7:0]               alpha,
  output logic                     end_of_row,
  output logic                     end_of_frame
);

  localparam int MAG_W = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;
  localparam int D_W   = MAG_W + 1;
  localparam int M_W   = MAG_W + 16;
  localparam int A_W   = (M_W > 32) ? M_W : 32;
  localparam int P_W   = A_W + 16;
  localparam int ACC_W = P_W + 1;
  localparam int R_W   = ACC_W - 4;
  localparam int CMP_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;

  // configuration
  logic [15:0] principal_x;
  logic [15:0] principal_y;
  logic [31:0] scale_x;
  logic [31:0] scale_y;
  logic [31:0] depth_scale;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [1:0]  color_order;

  // pixel position
  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;

  // captured item
  logic [15:0]      depth;
  logic             nonzero;
  logic [MAG_W-1:0] magx;
  logic [MAG_W-1:0] magy;
  logic             negx;
  logic             negy;
  logic [7:0]       r_q;
  logic [7:0]       g_q;
  logic [7:0]       b_q;
  logic             eor_q;
  logic             eof_q;

  // arithmetic results
  logic [M_W-1:0]   mx;
  logic [M_W-1:0]   my;
  logic [ACC_W-1:0] acc;
  logic [31:0]      px;
  logic [31:0]      py;
  logic [30:0]      pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      principal_x  <= '0;
      principal_y  <= '0;
      scale_x      <= '0;
      scale_y      <= '0;
      depth_scale  <= dpb_pkg::DEPTH_SCALE_RESET;
      frame_width  <= dpb_pkg::WIDTH_RESET;
      frame_height <= dpb_pkg::HEIGHT_RESET;
      color_order  <= dpb_pkg::ORDER_RGB;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpb_pkg::CFG_PRINCIPAL_X:  principal_x  <= cfg_data[15:0];
        dpb_pkg::CFG_PRINCIPAL_Y:  principal_y  <= cfg_data[15:0];
        dpb_pkg::CFG_SCALE_X:      scale_x      <= cfg_data;
        dpb_pkg::CFG_SCALE_Y:      scale_y      <= cfg_data;
        dpb_pkg::CFG_DEPTH_SCALE:  depth_scale  <= cfg_data;
        dpb_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        dpb_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        dpb_pkg::CFG_COLOR_ORDER:  color_order  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // offsets from the principal point, Q.4 pixels
  logic [D_W-1:0] dx;
  logic [D_W-1:0] dy;
  assign dx = D_W'({column_count, 4'b0000}) - D_W'(principal_x);
  assign dy = D_W'({row_count, 4'b0000}) - D_W'(principal_y);

  // end of row and frame
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic             eor;
  logic             eof;
  assign col_inc = CMP_W'(column_count) + CMP_W'(1);
  assign row_inc = CMP_W'(row_count) + CMP_W'(1);
  assign eor     = (col_inc >= CMP_W'(frame_width));
  assign eof     = eor && (row_inc >= CMP_W'(frame_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.load) begin
      if (eor) begin
        column_count <= '0;
        row_count    <= eof ? '0 : row_inc[COORD_BITS-1:0];
      end else begin
        column_count <= col_inc[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      depth   <= depth_raw;
      nonzero <= (depth_raw != 16'd0);
      negx    <= dx[D_W-1];
      negy    <= dy[D_W-1];
      magx    <= dx[D_W-1] ? MAG_W'(D_W'(0) - dx) : dx[MAG_W-1:0];
      magy    <= dy[D_W-1] ? MAG_W'(D_W'(0) - dy) : dy[MAG_W-1:0];
      eor_q   <= eor;
      eof_q   <= eof;
      case (color_order)
        dpb_pkg::ORDER_BGR: begin
          r_q <= color_byte2;
          g_q <= color_byte1;
          b_q <= color_byte0;
        end
        dpb_pkg::ORDER_MONO: begin
          r_q <= color_byte0;
          g_q <= color_byte0;
          b_q <= color_byte0;
        end
        default: begin
          r_q <= color_byte0;
          g_q <= color_byte1;
          b_q <= color_byte2;
        end
      endcase
    end
  end

  // shared multiplier
  logic [A_W-1:0] mul_a;
  logic [15:0]    mul_b;
  logic [P_W-1:0] prod;

  always_comb begin
    case (cmd.op)
      dpb_pkg::OP_MX: begin
        mul_a = A_W'(magx);
        mul_b = depth;
      end
      dpb_pkg::OP_MY: begin
        mul_a = A_W'(magy);
        mul_b = depth;
      end
      dpb_pkg::OP_Z: begin
        mul_a = A_W'(depth_scale);
        mul_b = depth;
      end
      dpb_pkg::OP_XL: begin
        mul_a = A_W'(mx);
        mul_b = scale_x[15:0];
      end
      dpb_pkg::OP_XH: begin
        mul_a = A_W'(mx);
        mul_b = scale_x[31:16];
      end
      dpb_pkg::OP_YL: begin
        mul_a = A_W'(my);
        mul_b = scale_y[15:0];
      end
      dpb_pkg::OP_YH: begin
        mul_a = A_W'(my);
        mul_b = scale_y[31:16];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  // z rounding, half up from Q.32
  logic [48:0] z_sum;
  logic [32:0] z_round;
  assign z_sum   = {1'b0, prod[47:0]} + 49'h0_0000_0000_8000;
  assign z_round = z_sum[48:16];

  // lateral rounding result and saturation with sign
  logic [R_W-1:0] rmag;
  logic           neg_sel;
  logic [31:0]    lat;
  assign rmag    = acc[ACC_W-1:4];
  assign neg_sel = (cmd.op == dpb_pkg::OP_YS) ? negy : negx;

  always_comb begin
    if (neg_sel) begin
      lat = (rmag > R_W'(dpb_pkg::Q1616_NEG_MAG)) ? 32'h8000_0000 : (32'd0 - rmag[31:0]);
    end else begin
      lat = (rmag > R_W'(dpb_pkg::Q1616_POS_MAX)) ? dpb_pkg::Q1616_POS_MAX : rmag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      dpb_pkg::OP_MX: mx <= prod[M_W-1:0];
      dpb_pkg::OP_MY: my <= prod[M_W-1:0];
      dpb_pkg::OP_Z: begin
        pz <= (z_round > 33'(dpb_pkg::Q1616_POS_MAX)) ? 31'h7fff_ffff : z_round[30:0];
      end
      dpb_pkg::OP_XL: acc <= ACC_W'(prod) + ACC_W'(20'h8_0000);
      dpb_pkg::OP_YL: acc <= ACC_W'(prod) + ACC_W'(20'h8_0000);
      dpb_pkg::OP_XH: acc <= ACC_W'(prod) + (acc >> 16);
      dpb_pkg::OP_YH: acc <= ACC_W'(prod) + (acc >> 16);
      dpb_pkg::OP_XS: px <= lat;
      dpb_pkg::OP_YS: py <= lat;
      default: ;
    endcase
  end

  // output register
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      point_x      <= nonzero ? px : 32'd0;
      point_y      <= nonzero ? py : 32'd0;
      point_z      <= nonzero ? pz : 31'd0;
      point_valid  <= nonzero;
      red          <= r_q;
      green        <= g_q;
      blue         <= b_q;
      alpha        <= dpb_pkg::ALPHA_VALUE;
      end_of_row   <= eor_q;
      end_of_frame <= eof_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/depth_pixel_backprojection.sv =====
// top level of the pinhole depth-pixel back-projection block
//
//   channel | direction | handshake            | beat payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_ready   | depth_raw, color_byte0..2
//   out     | output    | out_valid / out_ready | point_x/y/z, point_valid, rgb, alpha, flags
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one input beat per pass, taken only while idle: an accept step, nine steps through the single
// 32x16 multiplier and its accumulator, and a publish step that loads the output register
// reset is synchronous; it returns registers to their defaults and clears both counters
// the output register holds a finished point while the next pixel is worked on; if the
// sink stalls, the sequencer waits in its last step until the register frees up
// cfg writes are taken every cycle, and are meant to land only while the block is idle
`default_nettype none
`include "depth_pixel_backprojection_macros.svh"

module depth_pixel_backprojection #(
  parameter int COORD_BITS = 12
) (
  input  wire                clk,
  input  wire                rst,
  // pixel input
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [15:0]         depth_raw,
  input  wire [7:0]          color_byte0,
  input  wire [7:0]          color_byte1,
  input  wire [7:0]          color_byte2,
  // point output
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic [30:0]        point_z,
  output logic               point_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic               end_of_row,
  output logic               end_of_frame,
  // register writes
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data
);

  dpb_pkg::dp_cmd_t    cmd;
  dpb_pkg::dp_status_t status;

  // registers are plain flops, so a write beat never stalls
  assign cfg_ready = 1'b1;

  // sequencer: accept, multiply steps, publish
  dpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // counters, config, multiplier, rounding and the output register
  dpb_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .depth_raw    (depth_raw),
    .color_byte0  (color_byte0),
    .color_byte1  (color_byte1),
    .color_byte2  (color_byte2),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .point_valid  (point_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

  // one pixel in flight: the cycle after an accept takes nothing new
  `DPB_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second pixel taken while busy")

  // an invalid point carries zero coordinates
  `DPB_ASSERT(a_invalid_zero, out_valid && !point_valid |-> point_x == 0 && point_y == 0 && point_z == 0, "invalid point with nonzero xyz")

  // the frame ends only on a row end
  `DPB_ASSERT(a_eof_on_eor, out_valid && end_of_frame |-> end_of_row, "frame end without row end")

  // reset leaves the output empty and the input open
  `DPB_ASSERT_ALWAYS(a_reset_state, rst |=> !out_valid && in_ready, "bad state after reset")

endmodule

`default_nettype wire
